// File: rtl/kft_pkg.sv
// Package for the three-state Kalman filter: word format, payload structs,
// control word layout and the microcode program. Used by every rtl file.
package kft_pkg;

  localparam int FRAC_BITS = 16;
  localparam int WORD_BITS = 48;
  localparam int TIME_BITS = 47;
  localparam int RF_AW = 5;
  localparam int PC_BITS = 7;
  localparam int CFG_BITS = 47;
  localparam int CFG_IW = 3;

  typedef logic signed [WORD_BITS-1:0] word_t;

  localparam word_t WMAX = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam word_t WMIN = {1'b1, {(WORD_BITS-1){1'b0}}};
  localparam logic [TIME_BITS-1:0] TMAX = {TIME_BITS{1'b1}};

  // Fixed start covariance entries.
  localparam word_t P0_TENTH = word_t'(((64'd1 << FRAC_BITS) + 64'd5) / 64'd10);
  localparam word_t P0_BIG = word_t'(64'd10000 << FRAC_BITS);
  localparam word_t P0_TEN = word_t'(64'd10 << FRAC_BITS);
  localparam word_t P0_HUND = word_t'(64'd100 << FRAC_BITS);

  // Configuration register indexes.
  localparam logic [CFG_IW-1:0] CFG_STEP_DT = 3'd0;
  localparam logic [CFG_IW-1:0] CFG_PROC_NOISE = 3'd1;
  localparam logic [CFG_IW-1:0] CFG_MEAS_NOISE = 3'd2;
  localparam logic [CFG_IW-1:0] CFG_START_POS = 3'd3;
  localparam logic [CFG_IW-1:0] CFG_START_VEL = 3'd4;
  localparam logic [CFG_IW-1:0] CFG_START_ACC = 3'd5;
  localparam logic [CFG_IW-1:0] CFG_START_TIME = 3'd6;

  // Commands.
  localparam logic [1:0] CMD_INIT = 2'd0;
  localparam logic [1:0] CMD_PREDICT = 2'd1;
  localparam logic [1:0] CMD_UPDATE = 2'd2;

  typedef struct packed {
    logic [1:0] command;
    logic signed [31:0] measurement;
  } in_item_t;

  typedef struct packed {
    logic signed [WORD_BITS-1:0] position;
    logic signed [WORD_BITS-1:0] velocity;
    logic signed [WORD_BITS-1:0] acceleration;
    logic [TIME_BITS-1:0] elapsed_time;
    logic saturated;
  } out_item_t;

  // Micro-operations.
  localparam logic [3:0] OP_ADD = 4'd0;
  localparam logic [3:0] OP_SUB = 4'd1;
  localparam logic [3:0] OP_MUL = 4'd2;
  localparam logic [3:0] OP_DIV = 4'd3;
  localparam logic [3:0] OP_MOV = 4'd4;
  localparam logic [3:0] OP_LDS = 4'd5;
  localparam logic [3:0] OP_OUT = 4'd6;
  localparam logic [3:0] OP_TLD = 4'd7;
  localparam logic [3:0] OP_TADD = 4'd8;
  localparam logic [3:0] OP_JMP = 4'd9;
  localparam logic [3:0] OP_END = 4'd10;

  // Special operand sources for OP_LDS.
  localparam logic [3:0] SP_DT = 4'd0;
  localparam logic [3:0] SP_Q = 4'd1;
  localparam logic [3:0] SP_R = 4'd2;
  localparam logic [3:0] SP_Y = 4'd3;
  localparam logic [3:0] SP_POS = 4'd4;
  localparam logic [3:0] SP_VEL = 4'd5;
  localparam logic [3:0] SP_ACC = 4'd6;
  localparam logic [3:0] SP_TENTH = 4'd7;
  localparam logic [3:0] SP_BIG = 4'd8;
  localparam logic [3:0] SP_TEN = 4'd9;
  localparam logic [3:0] SP_HUND = 4'd10;

  // Write-back source select.
  localparam logic [1:0] WS_ALU = 2'd0;
  localparam logic [1:0] WS_OPA = 2'd1;
  localparam logic [1:0] WS_SPEC = 2'd2;

  // Register file map.
  localparam logic [4:0] RX0 = 5'd0, RX1 = 5'd1, RX2 = 5'd2;
  localparam logic [4:0] RPX0 = 5'd3, RPX1 = 5'd4, RPX2 = 5'd5;
  localparam logic [4:0] RP0 = 5'd6, RP1 = 5'd7, RP2 = 5'd8;
  localparam logic [4:0] RP3 = 5'd9, RP4 = 5'd10, RP5 = 5'd11;
  localparam logic [4:0] RP6 = 5'd12, RP7 = 5'd13, RP8 = 5'd14;
  localparam logic [4:0] RM0 = 5'd15, RM1 = 5'd16, RM2 = 5'd17;
  localparam logic [4:0] RM3 = 5'd18, RM4 = 5'd19, RM5 = 5'd20;
  localparam logic [4:0] RK0 = 5'd21, RK1 = 5'd22, RK2 = 5'd23;
  localparam logic [4:0] RDT = 5'd24, RQ = 5'd25, RR = 5'd26, RY = 5'd27;
  localparam logic [4:0] RS = 5'd28, RE = 5'd29, RT = 5'd30;

  // Program entry points and the shared output tail.
  localparam logic [PC_BITS-1:0] PC_INIT = 7'd0;
  localparam logic [PC_BITS-1:0] PC_TAIL = 7'd13;
  localparam logic [PC_BITS-1:0] PC_PREDICT = 7'd17;
  localparam logic [PC_BITS-1:0] PC_UPDATE = 7'd58;

  typedef struct packed {
    logic [3:0] op;
    logic [RF_AW-1:0] dst;
    logic [RF_AW-1:0] a;
    logic [RF_AW-1:0] b;
    logic [PC_BITS-1:0] target;
  } ucode_t;

  // Control from the sequencer to the datapath.
  typedef struct packed {
    logic [RF_AW-1:0] rd_a;
    logic [RF_AW-1:0] rd_b;
    logic wr_en;
    logic [RF_AW-1:0] wr_addr;
    logic [1:0] wr_sel;
    logic [3:0] spec;
    logic alu_start;
    logic [3:0] alu_op;
    logic out_we;
    logic [1:0] out_slot;
    logic time_ld;
    logic time_add;
    logic finish;
  } ctrl_t;

  function automatic ucode_t mk(input logic [3:0] op, input logic [4:0] dst,
                                input logic [4:0] a, input logic [4:0] b);
    ucode_t u;
    u.op = op;
    u.dst = dst;
    u.a = a;
    u.b = b;
    u.target = '0;
    return u;
  endfunction

  function automatic ucode_t mkj(input logic [PC_BITS-1:0] target);
    ucode_t u;
    u = mk(OP_JMP, 5'd0, 5'd0, 5'd0);
    u.target = target;
    return u;
  endfunction

  function automatic logic [PC_BITS-1:0] entry_of(input logic [1:0] cmd);
    case (cmd)
      CMD_INIT: return PC_INIT;
      CMD_PREDICT: return PC_PREDICT;
      CMD_UPDATE: return PC_UPDATE;
      default: return PC_TAIL;
    endcase
  endfunction

  // The filter program, one control word per step.
  function automatic ucode_t ucode_rom(input logic [PC_BITS-1:0] pc);
    case (pc)
      // Init: start state and fixed covariance.
      7'd0: return mk(OP_LDS, RX0, {1'b0, SP_POS}, 5'd0);
      7'd1: return mk(OP_LDS, RX1, {1'b0, SP_VEL}, 5'd0);
      7'd2: return mk(OP_LDS, RX2, {1'b0, SP_ACC}, 5'd0);
      7'd3: return mk(OP_LDS, RP0, {1'b0, SP_TENTH}, 5'd0);
      7'd4: return mk(OP_LDS, RP1, {1'b0, SP_TENTH}, 5'd0);
      7'd5: return mk(OP_LDS, RP2, {1'b0, SP_TENTH}, 5'd0);
      7'd6: return mk(OP_LDS, RP3, {1'b0, SP_TENTH}, 5'd0);
      7'd7: return mk(OP_LDS, RP4, {1'b0, SP_BIG}, 5'd0);
      7'd8: return mk(OP_LDS, RP5, {1'b0, SP_TEN}, 5'd0);
      7'd9: return mk(OP_LDS, RP6, {1'b0, SP_TENTH}, 5'd0);
      7'd10: return mk(OP_LDS, RP7, {1'b0, SP_TEN}, 5'd0);
      7'd11: return mk(OP_LDS, RP8, {1'b0, SP_HUND}, 5'd0);
      7'd12: return mk(OP_TLD, 5'd0, 5'd0, 5'd0);
      // Tail: show the state estimate.
      7'd13: return mk(OP_OUT, 5'd0, RX0, 5'd0);
      7'd14: return mk(OP_OUT, 5'd1, RX1, 5'd0);
      7'd15: return mk(OP_OUT, 5'd2, RX2, 5'd0);
      7'd16: return mk(OP_END, 5'd0, 5'd0, 5'd0);
      // Predict: state.
      7'd17: return mk(OP_LDS, RDT, {1'b0, SP_DT}, 5'd0);
      7'd18: return mk(OP_LDS, RQ, {1'b0, SP_Q}, 5'd0);
      7'd19: return mk(OP_MUL, RT, RDT, RX1);
      7'd20: return mk(OP_ADD, RPX0, RX0, RT);
      7'd21: return mk(OP_MUL, RT, RDT, RX2);
      7'd22: return mk(OP_ADD, RPX1, RX1, RT);
      7'd23: return mk(OP_MOV, RPX2, RX2, 5'd0);
      // Predict: M = A*P, upper two rows.
      7'd24: return mk(OP_MUL, RT, RDT, RP3);
      7'd25: return mk(OP_ADD, RM0, RP0, RT);
      7'd26: return mk(OP_MUL, RT, RDT, RP6);
      7'd27: return mk(OP_ADD, RM3, RP3, RT);
      7'd28: return mk(OP_MUL, RT, RDT, RP4);
      7'd29: return mk(OP_ADD, RM1, RP1, RT);
      7'd30: return mk(OP_MUL, RT, RDT, RP7);
      7'd31: return mk(OP_ADD, RM4, RP4, RT);
      7'd32: return mk(OP_MUL, RT, RDT, RP5);
      7'd33: return mk(OP_ADD, RM2, RP2, RT);
      7'd34: return mk(OP_MUL, RT, RDT, RP8);
      7'd35: return mk(OP_ADD, RM5, RP5, RT);
      // Predict: P = M*A^T; the last row of M is the last row of P.
      7'd36: return mk(OP_MUL, RT, RDT, RM1);
      7'd37: return mk(OP_ADD, RP0, RM0, RT);
      7'd38: return mk(OP_MUL, RT, RDT, RM2);
      7'd39: return mk(OP_ADD, RP1, RM1, RT);
      7'd40: return mk(OP_MOV, RP2, RM2, 5'd0);
      7'd41: return mk(OP_MUL, RT, RDT, RM4);
      7'd42: return mk(OP_ADD, RP3, RM3, RT);
      7'd43: return mk(OP_MUL, RT, RDT, RM5);
      7'd44: return mk(OP_ADD, RP4, RM4, RT);
      7'd45: return mk(OP_MOV, RP5, RM5, 5'd0);
      7'd46: return mk(OP_MUL, RT, RDT, RP7);
      7'd47: return mk(OP_ADD, RP6, RP6, RT);
      7'd48: return mk(OP_MUL, RT, RDT, RP8);
      7'd49: return mk(OP_ADD, RP7, RP7, RT);
      // Predict: process noise.
      7'd50: return mk(OP_ADD, RP0, RP0, RQ);
      7'd51: return mk(OP_ADD, RP1, RP1, RQ);
      7'd52: return mk(OP_ADD, RP3, RP3, RQ);
      7'd53: return mk(OP_ADD, RP4, RP4, RQ);
      7'd54: return mk(OP_OUT, 5'd0, RPX0, 5'd0);
      7'd55: return mk(OP_OUT, 5'd1, RPX1, 5'd0);
      7'd56: return mk(OP_OUT, 5'd2, RPX2, 5'd0);
      7'd57: return mk(OP_END, 5'd0, 5'd0, 5'd0);
      // Update: gain.
      7'd58: return mk(OP_LDS, RR, {1'b0, SP_R}, 5'd0);
      7'd59: return mk(OP_LDS, RY, {1'b0, SP_Y}, 5'd0);
      7'd60: return mk(OP_ADD, RS, RP0, RR);
      7'd61: return mk(OP_DIV, RK0, RP0, RS);
      7'd62: return mk(OP_DIV, RK1, RP3, RS);
      7'd63: return mk(OP_DIV, RK2, RP6, RS);
      // Update: state correction.
      7'd64: return mk(OP_SUB, RE, RY, RPX0);
      7'd65: return mk(OP_MUL, RT, RK0, RE);
      7'd66: return mk(OP_ADD, RPX0, RPX0, RT);
      7'd67: return mk(OP_MUL, RT, RK1, RE);
      7'd68: return mk(OP_ADD, RPX1, RPX1, RT);
      7'd69: return mk(OP_MUL, RT, RK2, RE);
      7'd70: return mk(OP_ADD, RPX2, RPX2, RT);
      // Update: covariance; row zero goes last so the others see it unchanged.
      7'd71: return mk(OP_MUL, RT, RK1, RP0);
      7'd72: return mk(OP_SUB, RP3, RP3, RT);
      7'd73: return mk(OP_MUL, RT, RK1, RP1);
      7'd74: return mk(OP_SUB, RP4, RP4, RT);
      7'd75: return mk(OP_MUL, RT, RK1, RP2);
      7'd76: return mk(OP_SUB, RP5, RP5, RT);
      7'd77: return mk(OP_MUL, RT, RK2, RP0);
      7'd78: return mk(OP_SUB, RP6, RP6, RT);
      7'd79: return mk(OP_MUL, RT, RK2, RP1);
      7'd80: return mk(OP_SUB, RP7, RP7, RT);
      7'd81: return mk(OP_MUL, RT, RK2, RP2);
      7'd82: return mk(OP_SUB, RP8, RP8, RT);
      7'd83: return mk(OP_MUL, RT, RK0, RP0);
      7'd84: return mk(OP_SUB, RP0, RP0, RT);
      7'd85: return mk(OP_MUL, RT, RK0, RP1);
      7'd86: return mk(OP_SUB, RP1, RP1, RT);
      7'd87: return mk(OP_MUL, RT, RK0, RP2);
      7'd88: return mk(OP_SUB, RP2, RP2, RT);
      7'd89: return mk(OP_MOV, RX0, RPX0, 5'd0);
      7'd90: return mk(OP_MOV, RX1, RPX1, 5'd0);
      7'd91: return mk(OP_MOV, RX2, RPX2, 5'd0);
      7'd92: return mk(OP_TADD, 5'd0, 5'd0, 5'd0);
      7'd93: return mkj(PC_TAIL);
      default: return mk(OP_END, 5'd0, 5'd0, 5'd0);
    endcase
  endfunction

endpackage

// File: rtl/kalman_filter_three_state_top.sv
// Three-state Kalman filter, top level: configuration registers, filter time,
// output register and the glue around the sequencer, ALU and register file.
// Each divide and multiply runs in the shared ALU, and one item is in work at a
// time: a new request is taken only once the last result has been loaded into
// the output register, which waits while the receiver stalls.
// Reset (synchronous, rst high) clears state, control and valid bits at once.
module kalman_filter_three_state_top (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        req_valid,
  output logic                        req_stall,
  input  kft_pkg::in_item_t           req,
  output logic                        rsp_valid,
  input  logic                        rsp_stall,
  output kft_pkg::out_item_t          rsp,
  input  logic                        cfg_we,
  input  logic [kft_pkg::CFG_IW-1:0]  cfg_index,
  input  logic [kft_pkg::CFG_BITS-1:0] cfg_data
);
  import kft_pkg::*;

  logic [16:0] step_dt;
  logic [31:0] process_noise, measurement_noise;
  logic [31:0] start_position, start_velocity, start_acceleration;
  logic [TIME_BITS-1:0] start_time;

  logic [TIME_BITS-1:0] filter_time;
  logic [TIME_BITS:0] time_sum;
  logic saturated;
  logic signed [31:0] meas;
  word_t show0, show1, show2;

  logic accept, busy, out_free;
  ctrl_t ctrl;
  word_t opa, opb, alu_result, spec_val, wr_data;
  logic alu_done, alu_sat;

  assign req_stall = busy || rst;
  assign accept = req_valid && !req_stall;
  assign out_free = !rsp_valid || !rsp_stall;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      step_dt <= 17'd2185;
      process_noise <= 32'd3277;
      measurement_noise <= 32'd327680;
      start_position <= 32'd65536;
      start_velocity <= 32'd0;
      start_acceleration <= 32'hFFF6_30A4;
      start_time <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_STEP_DT: step_dt <= cfg_data[16:0];
        CFG_PROC_NOISE: process_noise <= cfg_data[31:0];
        CFG_MEAS_NOISE: measurement_noise <= cfg_data[31:0];
        CFG_START_POS: start_position <= cfg_data[31:0];
        CFG_START_VEL: start_velocity <= cfg_data[31:0];
        CFG_START_ACC: start_acceleration <= cfg_data[31:0];
        CFG_START_TIME: start_time <= cfg_data[TIME_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Special operands for the load step.
  always_comb begin
    case (ctrl.spec)
      SP_DT: spec_val = word_t'(step_dt);
      SP_Q: spec_val = word_t'(process_noise);
      SP_R: spec_val = word_t'(measurement_noise);
      SP_Y: spec_val = word_t'(meas);
      SP_POS: spec_val = word_t'(signed'(start_position));
      SP_VEL: spec_val = word_t'(signed'(start_velocity));
      SP_ACC: spec_val = word_t'(signed'(start_acceleration));
      SP_TENTH: spec_val = P0_TENTH;
      SP_BIG: spec_val = P0_BIG;
      SP_TEN: spec_val = P0_TEN;
      SP_HUND: spec_val = P0_HUND;
      default: spec_val = '0;
    endcase
  end

  // Write-back select.
  always_comb begin
    case (ctrl.wr_sel)
      WS_OPA: wr_data = opa;
      WS_SPEC: wr_data = spec_val;
      default: wr_data = alu_result;
    endcase
  end

  kft_sequencer u_seq (
    .clk(clk),
    .rst(rst),
    .start(accept),
    .command(req.command),
    .alu_done(alu_done),
    .out_free(out_free),
    .busy(busy),
    .ctrl(ctrl)
  );

  kft_regfile u_rf (
    .clk(clk),
    .rst(rst),
    .rd_addr_a(ctrl.rd_a),
    .rd_addr_b(ctrl.rd_b),
    .rd_data_a(opa),
    .rd_data_b(opb),
    .wr_en(ctrl.wr_en),
    .wr_addr(ctrl.wr_addr),
    .wr_data(wr_data)
  );

  kft_alu u_alu (
    .clk(clk),
    .rst(rst),
    .start(ctrl.alu_start),
    .op(ctrl.alu_op),
    .a(opa),
    .b(opb),
    .done(alu_done),
    .result(alu_result),
    .sat(alu_sat)
  );

  assign time_sum = {1'b0, filter_time} + (TIME_BITS + 1)'(step_dt);

  // Filter time, saturation flag and the measurement of the current transaction.
  always_ff @(posedge clk) begin
    if (rst) begin
      filter_time <= '0;
      saturated <= 1'b0;
    end else begin
      if (accept) begin
        saturated <= 1'b0;
      end else if ((alu_done && alu_sat && ctrl.wr_en) ||
                   (ctrl.time_add && time_sum[TIME_BITS])) begin
        saturated <= 1'b1;
      end
      if (ctrl.time_ld) begin
        filter_time <= start_time;
      end else if (ctrl.time_add) begin
        filter_time <= time_sum[TIME_BITS] ? TMAX : time_sum[TIME_BITS-1:0];
      end
    end
    if (accept) begin
      meas <= req.measurement;
    end
  end

  // Staging of the shown estimate.
  always_ff @(posedge clk) begin
    if (ctrl.out_we) begin
      case (ctrl.out_slot)
        2'd0: show0 <= opa;
        2'd1: show1 <= opa;
        default: show2 <= opa;
      endcase
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (ctrl.finish) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
    if (ctrl.finish) begin
      rsp.position <= show0;
      rsp.velocity <= show1;
      rsp.acceleration <= show2;
      rsp.elapsed_time <= filter_time;
      rsp.saturated <= saturated;
    end
  end

endmodule

// File: rtl/kft_regfile.sv
// Register file of the filter datapath: 32 words, two registered read ports.
// Depends on kft_pkg; entries never written since reset read as zero.
module kft_regfile (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [kft_pkg::RF_AW-1:0] rd_addr_a,
  input  logic [kft_pkg::RF_AW-1:0] rd_addr_b,
  output kft_pkg::word_t         rd_data_a,
  output kft_pkg::word_t         rd_data_b,
  input  logic                   wr_en,
  input  logic [kft_pkg::RF_AW-1:0] wr_addr,
  input  kft_pkg::word_t         wr_data
);
  import kft_pkg::*;

  localparam int DEPTH = 1 << RF_AW;

  word_t mem [DEPTH];
  logic [DEPTH-1:0] valid;

  // Write port and per-entry valid bits.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rst) begin
      valid <= '0;
    end else if (wr_en) begin
      valid[wr_addr] <= 1'b1;
    end
  end

  // Registered reads; an invalid entry reads as zero.
  always_ff @(posedge clk) begin
    rd_data_a <= valid[rd_addr_a] ? mem[rd_addr_a] : '0;
    rd_data_b <= valid[rd_addr_b] ? mem[rd_addr_b] : '0;
  end

endmodule

// File: rtl/kft_alu.sv
// Shared arithmetic unit: saturating add/subtract, multi-cycle fixed-point
// multiply (24-bit partial products) and bit-serial divide. Depends on kft_pkg.
module kft_alu (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic [3:0]     op,
  input  kft_pkg::word_t a,
  input  kft_pkg::word_t b,
  output logic           done,
  output kft_pkg::word_t result,
  output logic           sat
);
  import kft_pkg::*;

  localparam int HW = WORD_BITS / 2;
  localparam int PW = 2 * WORD_BITS;
  localparam int RW = PW - FRAC_BITS;
  localparam int NW = WORD_BITS + FRAC_BITS;
  localparam int CW = $clog2(NW);

  localparam logic [2:0] AS_IDLE = 3'd0;
  localparam logic [2:0] AS_ADD = 3'd1;
  localparam logic [2:0] AS_MUL = 3'd2;
  localparam logic [2:0] AS_MFIN = 3'd3;
  localparam logic [2:0] AS_DIV = 3'd4;
  localparam logic [2:0] AS_DFIN = 3'd5;
  localparam logic [2:0] AS_DZERO = 3'd6;

  logic [2:0] st;
  logic neg;
  logic [WORD_BITS-1:0] xm, ym;
  logic [PW-1:0] acc;
  logic [CW-1:0] cnt;
  logic [WORD_BITS:0] sum;
  logic [NW-1:0] num;
  logic [NW-1:0] quo;
  logic [WORD_BITS-1:0] rem;

  logic [WORD_BITS-1:0] amag, bmag;
  logic [HW-1:0] xpart, ypart;
  logic [2*HW-1:0] pp;
  logic [PW-1:0] pp_sh;
  logic [WORD_BITS:0] trial;
  logic trial_ok;
  logic [PW-1:0] rnd;
  logic [WORD_BITS:0] dminus;
  logic [NW:0] qrnd;
  logic [WORD_BITS:0] tw;

  // Magnitude and sign to a saturated word; top bit of the result is the flag.
  function automatic logic [WORD_BITS:0] to_word(input logic n, input logic [RW-1:0] m);
    logic [RW-1:0] half;
    logic [WORD_BITS-1:0] lo;
    half = RW'(1) << (WORD_BITS - 1);
    lo = m[WORD_BITS-1:0];
    if (n) begin
      if (m >= half) begin
        return {m > half, WMIN};
      end
      return {1'b0, -lo};
    end
    if (m >= half) begin
      return {1'b1, WMAX};
    end
    return {1'b0, lo};
  endfunction

  assign amag = a[WORD_BITS-1] ? -a : a;
  assign bmag = b[WORD_BITS-1] ? -b : b;

  // One partial product per cycle.
  assign xpart = cnt[0] ? xm[WORD_BITS-1:HW] : xm[HW-1:0];
  assign ypart = cnt[1] ? ym[WORD_BITS-1:HW] : ym[HW-1:0];
  assign pp = xpart * ypart;
  assign pp_sh = PW'(pp) << (HW * (32'(cnt[0]) + 32'(cnt[1])));

  // Restoring division step.
  assign trial = {rem, num[NW-1]};
  assign trial_ok = trial >= {1'b0, ym};

  assign rnd = acc + (PW'(1) << (FRAC_BITS - 1));
  assign dminus = {1'b0, ym} - {1'b0, rem};
  assign qrnd = {1'b0, quo} + NW'({1'b0, rem} >= dminus);

  always_comb begin
    tw = '0;
    done = 1'b0;
    case (st)
      AS_ADD: begin
        done = 1'b1;
        if (!sum[WORD_BITS] && sum[WORD_BITS-1]) begin
          tw = {1'b1, WMAX};
        end else if (sum[WORD_BITS] && !sum[WORD_BITS-1]) begin
          tw = {1'b1, WMIN};
        end else begin
          tw = {1'b0, sum[WORD_BITS-1:0]};
        end
      end
      AS_MFIN: begin
        done = 1'b1;
        tw = to_word(neg, rnd[PW-1:FRAC_BITS]);
      end
      AS_DFIN: begin
        done = 1'b1;
        tw = to_word(neg, RW'(qrnd));
      end
      AS_DZERO: begin
        done = 1'b1;
        tw = {1'b1, {WORD_BITS{1'b0}}};
      end
      default: tw = '0;
    endcase
  end

  assign result = tw[WORD_BITS-1:0];
  assign sat = tw[WORD_BITS];

  // Operation sequencing.
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= AS_IDLE;
    end else begin
      case (st)
        AS_IDLE: begin
          if (start) begin
            neg <= a[WORD_BITS-1] ^ b[WORD_BITS-1];
            xm <= amag;
            ym <= bmag;
            acc <= '0;
            cnt <= '0;
            rem <= '0;
            quo <= '0;
            num <= {amag, {FRAC_BITS{1'b0}}};
            case (op)
              OP_ADD: begin
                sum <= {a[WORD_BITS-1], a} + {b[WORD_BITS-1], b};
                st <= AS_ADD;
              end
              OP_SUB: begin
                sum <= {a[WORD_BITS-1], a} - {b[WORD_BITS-1], b};
                st <= AS_ADD;
              end
              OP_MUL: st <= AS_MUL;
              OP_DIV: st <= (b == '0) ? AS_DZERO : AS_DIV;
              default: st <= AS_IDLE;
            endcase
          end
        end
        AS_MUL: begin
          acc <= acc + pp_sh;
          cnt <= cnt + 1'b1;
          if (cnt == CW'(3)) begin
            st <= AS_MFIN;
          end
        end
        AS_DIV: begin
          rem <= trial_ok ? WORD_BITS'(trial - {1'b0, ym}) : trial[WORD_BITS-1:0];
          quo <= {quo[NW-2:0], trial_ok};
          num <= {num[NW-2:0], 1'b0};
          cnt <= cnt + 1'b1;
          if (cnt == CW'(NW - 1)) begin
            st <= AS_DFIN;
          end
        end
        default: st <= AS_IDLE;
      endcase
    end
  end

endmodule

// File: rtl/kft_sequencer.sv
// Microcode sequencer: step counter, control word register and the
// fetch/execute/wait cycle of each step. Depends on kft_pkg for the program.
module kft_sequencer (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic [1:0]     command,
  input  logic           alu_done,
  input  logic           out_free,
  output logic           busy,
  output kft_pkg::ctrl_t ctrl
);
  import kft_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_FETCH = 3'd1;
  localparam logic [2:0] ST_EXEC = 3'd2;
  localparam logic [2:0] ST_WAIT = 3'd3;
  localparam logic [2:0] ST_FIN = 3'd4;

  logic [2:0] st, st_next;
  logic [PC_BITS-1:0] pc, pc_next;
  ucode_t ir;
  ucode_t rom_word;

  assign rom_word = ucode_rom(pc);
  assign busy = (st != ST_IDLE);

  // Control word decode.
  always_comb begin
    ctrl = '0;
    ctrl.rd_a = rom_word.a;
    ctrl.rd_b = rom_word.b;
    ctrl.wr_addr = ir.dst;
    ctrl.spec = ir.a[3:0];
    ctrl.alu_op = ir.op;
    ctrl.out_slot = ir.dst[1:0];
    st_next = st;
    pc_next = pc;
    case (st)
      ST_IDLE: begin
        if (start) begin
          pc_next = entry_of(command);
          st_next = ST_FETCH;
        end
      end
      ST_FETCH: st_next = ST_EXEC;
      ST_EXEC: begin
        st_next = ST_FETCH;
        pc_next = pc + 1'b1;
        case (ir.op)
          OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
            ctrl.alu_start = 1'b1;
            st_next = ST_WAIT;
            pc_next = pc;
          end
          OP_MOV: begin
            ctrl.wr_en = 1'b1;
            ctrl.wr_sel = WS_OPA;
          end
          OP_LDS: begin
            ctrl.wr_en = 1'b1;
            ctrl.wr_sel = WS_SPEC;
          end
          OP_OUT: ctrl.out_we = 1'b1;
          OP_TLD: ctrl.time_ld = 1'b1;
          OP_TADD: ctrl.time_add = 1'b1;
          OP_JMP: pc_next = ir.target;
          default: begin
            st_next = ST_FIN;
            pc_next = pc;
          end
        endcase
      end
      ST_WAIT: begin
        if (alu_done) begin
          ctrl.wr_en = 1'b1;
          ctrl.wr_sel = WS_ALU;
          pc_next = pc + 1'b1;
          st_next = ST_FETCH;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          ctrl.finish = 1'b1;
          st_next = ST_IDLE;
        end
      end
      default: st_next = ST_IDLE;
    endcase
  end

  // Step counter and control word register.
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= ST_IDLE;
      pc <= '0;
    end else begin
      st <= st_next;
      pc <= pc_next;
    end
    if (st == ST_FETCH) begin
      ir <= rom_word;
    end
  end

endmodule

// File: test/tb_top.sv
// Testbench for the three-state Kalman filter: drives commands through the
// request channel, predicts every estimate in fixed point and checks each result.
// Depends on kft_pkg and kalman_filter_three_state_top.
module tb_top;
  import kft_pkg::*;

  localparam longint W_MAX = 64'sd140737488355327;
  localparam longint W_MIN = -W_MAX - 1;
  localparam logic [63:0] T_MAX = (64'd1 << 47) - 64'd1;

  logic clk;
  logic rst;
  logic req_valid;
  logic req_stall;
  in_item_t req;
  logic rsp_valid;
  logic rsp_stall;
  out_item_t rsp;
  logic cfg_we;
  logic [CFG_IW-1:0] cfg_index;
  logic [CFG_BITS-1:0] cfg_data;

  kalman_filter_three_state_top dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Filter state as the testbench sees it.
  longint est_x[3];
  longint pred_x[3];
  longint cov[9];
  logic [63:0] ftime;
  bit ovf;

  // Shadow copies of the configuration registers.
  logic [63:0] dt_reg, qn_reg, rn_reg, t0_reg;
  logic [31:0] pos0_reg, vel0_reg, acc0_reg;

  out_item_t expected_est[$];
  int errors;
  int send_pct;
  int recv_pct;
  int hold_req;
  int hold_done;
  int hold_cnt;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #(12 * 4000000);
    $display("tb_top NOT OK");
    $finish;
  end

  function automatic logic [63:0] mag(input longint v);
    return (v < 0) ? 64'(-v) : 64'(v);
  endfunction

  function automatic longint to_word(input bit neg, input logic [63:0] m);
    if (neg) begin
      if (m >= 64'h8000_0000_0000) begin
        if (m > 64'h8000_0000_0000) ovf = 1'b1;
        return W_MIN;
      end
      return -longint'(m);
    end
    if (m > 64'h7FFF_FFFF_FFFF) begin
      ovf = 1'b1;
      return W_MAX;
    end
    return longint'(m);
  endfunction

  function automatic longint sat_add(input longint a, input longint b);
    longint s;
    s = a + b;
    if (s > W_MAX) begin ovf = 1'b1; return W_MAX; end
    if (s < W_MIN) begin ovf = 1'b1; return W_MIN; end
    return s;
  endfunction

  function automatic longint sat_sub(input longint a, input longint b);
    longint s;
    s = a - b;
    if (s > W_MAX) begin ovf = 1'b1; return W_MAX; end
    if (s < W_MIN) begin ovf = 1'b1; return W_MIN; end
    return s;
  endfunction

  // Fixed-point multiply, round to nearest with ties away from zero.
  function automatic longint fx_mul(input longint a, input longint b);
    logic [127:0] p;
    bit neg;
    neg = (a < 0) != (b < 0);
    p = {64'd0, mag(a)} * {64'd0, mag(b)};
    p = p + 128'd32768;
    if (p[127:80] != 0) begin
      ovf = 1'b1;
      return neg ? W_MIN : W_MAX;
    end
    return to_word(neg, p[79:16]);
  endfunction

  // Fixed-point divide; a zero divisor gives zero and flags saturation.
  function automatic longint fx_div(input longint num, input longint den);
    logic [127:0] n, d, q, r;
    bit neg;
    neg = (num < 0) != (den < 0);
    if (den == 0) begin
      ovf = 1'b1;
      return 0;
    end
    n = {64'd0, mag(num)} << 16;
    d = {64'd0, mag(den)};
    q = n / d;
    r = n % d;
    if (r >= d - r) q = q + 128'd1;
    if (q[127:64] != 0) begin
      ovf = 1'b1;
      return neg ? W_MIN : W_MAX;
    end
    return to_word(neg, q[63:0]);
  endfunction

  function automatic longint from_s32(input logic [31:0] v);
    longint x;
    x = longint'(signed'(v));
    return to_word(x < 0, mag(x));
  endfunction

  // Advance the expected filter state by one command and return its result.
  function automatic out_item_t filter_step(input in_item_t it);
    out_item_t o;
    longint m[9];
    longint k[3];
    longint row0[3];
    longint dt, q, s, e, y;
    bit show_pred;
    show_pred = 1'b0;
    ovf = 1'b0;
    case (it.command)
      CMD_INIT: begin
        est_x[0] = from_s32(pos0_reg);
        est_x[1] = from_s32(vel0_reg);
        est_x[2] = from_s32(acc0_reg);
        cov = '{P0_TENTH, P0_TENTH, P0_TENTH, P0_TENTH, P0_BIG, P0_TEN,
                P0_TENTH, P0_TEN, P0_HUND};
        ftime = t0_reg & T_MAX;
      end
      CMD_PREDICT: begin
        dt = to_word(1'b0, dt_reg);
        q = to_word(1'b0, qn_reg);
        pred_x[0] = sat_add(est_x[0], fx_mul(dt, est_x[1]));
        pred_x[1] = sat_add(est_x[1], fx_mul(dt, est_x[2]));
        pred_x[2] = est_x[2];
        for (int j = 0; j < 3; j++) begin
          m[j] = sat_add(cov[j], fx_mul(dt, cov[3 + j]));
          m[3 + j] = sat_add(cov[3 + j], fx_mul(dt, cov[6 + j]));
          m[6 + j] = cov[6 + j];
        end
        for (int i = 0; i < 3; i++) begin
          cov[i * 3] = sat_add(m[i * 3], fx_mul(dt, m[i * 3 + 1]));
          cov[i * 3 + 1] = sat_add(m[i * 3 + 1], fx_mul(dt, m[i * 3 + 2]));
          cov[i * 3 + 2] = m[i * 3 + 2];
        end
        cov[0] = sat_add(cov[0], q);
        cov[1] = sat_add(cov[1], q);
        cov[3] = sat_add(cov[3], q);
        cov[4] = sat_add(cov[4], q);
        show_pred = 1'b1;
      end
      CMD_UPDATE: begin
        y = from_s32(it.measurement);
        s = sat_add(cov[0], to_word(1'b0, rn_reg));
        for (int i = 0; i < 3; i++) begin
          k[i] = fx_div(cov[i * 3], s);
          row0[i] = cov[i];
        end
        e = sat_sub(y, pred_x[0]);
        for (int i = 0; i < 3; i++) pred_x[i] = sat_add(pred_x[i], fx_mul(k[i], e));
        for (int i = 0; i < 3; i++)
          for (int j = 0; j < 3; j++)
            cov[i * 3 + j] = sat_sub(cov[i * 3 + j], fx_mul(k[i], row0[j]));
        est_x = pred_x;
        ftime = ftime + dt_reg;
        if (ftime > T_MAX) begin
          ftime = T_MAX;
          ovf = 1'b1;
        end
      end
      default: ;
    endcase
    o.position = show_pred ? 48'(pred_x[0]) : 48'(est_x[0]);
    o.velocity = show_pred ? 48'(pred_x[1]) : 48'(est_x[1]);
    o.acceleration = show_pred ? 48'(pred_x[2]) : 48'(est_x[2]);
    o.elapsed_time = ftime[46:0];
    o.saturated = ovf;
    return o;
  endfunction

  // Write one configuration register and its shadow copy.
  task automatic cfg_write(input logic [CFG_IW-1:0] idx, input logic [63:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[CFG_BITS-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_STEP_DT: dt_reg = val & 64'h1FFFF;
      CFG_PROC_NOISE: qn_reg = val & 64'hFFFF_FFFF;
      CFG_MEAS_NOISE: rn_reg = val & 64'hFFFF_FFFF;
      CFG_START_POS: pos0_reg = val[31:0];
      CFG_START_VEL: vel0_reg = val[31:0];
      CFG_START_ACC: acc0_reg = val[31:0];
      CFG_START_TIME: t0_reg = val & T_MAX;
      default: ;
    endcase
  endtask

  // Offer one command and record its expected result once it is accepted.
  task automatic send_cmd(input logic [1:0] c, input logic [31:0] meas);
    in_item_t it;
    it.command = c;
    it.measurement = meas;
    if ($urandom_range(99) < send_pct) begin
      req_valid <= 1'b0;
      if ($urandom_range(19) == 0) repeat ($urandom_range(1, 600)) @(posedge clk);
      else repeat ($urandom_range(1, 40)) @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= it;
    do @(posedge clk); while (req_stall);
    expected_est.push_back(filter_step(it));
  endtask

  // Let every outstanding transaction come back before touching registers.
  task automatic drain;
    req_valid <= 1'b0;
    while (expected_est.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_word32();
    case ($urandom_range(4))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'(int'($urandom_range(0, 400000)) - 200000);
      default: return $urandom;
    endcase
  endfunction

  // Measurement close to the predicted position, with occasional wild values.
  function automatic logic [31:0] near_meas();
    if ($urandom_range(9) == 0 || pred_x[0] > 64'sd2147483647 ||
        pred_x[0] < -64'sd2147483648)
      return $urandom;
    return 32'(pred_x[0] + longint'($urandom_range(0, 131072)) - 65536);
  endfunction

  task automatic random_config;
    case ($urandom_range(4))
      0: cfg_write(CFG_STEP_DT, 64'd1);
      1: cfg_write(CFG_STEP_DT, 64'd65536);
      2: cfg_write(CFG_STEP_DT, 64'd2185);
      3: cfg_write(CFG_STEP_DT, 64'($urandom_range(1, 4000)));
      default: cfg_write(CFG_STEP_DT, 64'($urandom_range(0, 131071)));
    endcase
    case ($urandom_range(3))
      0: cfg_write(CFG_PROC_NOISE, 64'd0);
      1: cfg_write(CFG_PROC_NOISE, 64'hFFFF_FFFF);
      2: cfg_write(CFG_PROC_NOISE, 64'($urandom_range(0, 70000)));
      default: cfg_write(CFG_PROC_NOISE, 64'($urandom));
    endcase
    case ($urandom_range(3))
      0: cfg_write(CFG_MEAS_NOISE, 64'd1);
      1: cfg_write(CFG_MEAS_NOISE, 64'hFFFF_FFFF);
      2: cfg_write(CFG_MEAS_NOISE, 64'($urandom_range(1, 2000000)));
      default: cfg_write(CFG_MEAS_NOISE, 64'($urandom));
    endcase
    cfg_write(CFG_START_POS, 64'(rand_word32()));
    cfg_write(CFG_START_VEL, 64'(rand_word32()));
    cfg_write(CFG_START_ACC, 64'(rand_word32()));
    case ($urandom_range(3))
      0: cfg_write(CFG_START_TIME, 64'd0);
      1: cfg_write(CFG_START_TIME, T_MAX);
      2: cfg_write(CFG_START_TIME, T_MAX - 64'($urandom_range(0, 200000)));
      default: cfg_write(CFG_START_TIME, {$urandom, $urandom} & T_MAX);
    endcase
  endtask

  // Corner cases: zero innovation variance, update before predict, the
  // unused command code, extreme measurements and saturating covariance.
  task automatic test_directed;
    send_pct = 0;
    recv_pct = 0;
    cfg_write(CFG_MEAS_NOISE, 64'd0);
    send_cmd(CMD_UPDATE, 32'h0001_0000);
    send_cmd(2'd3, 32'h0);
    drain();
    cfg_write(CFG_MEAS_NOISE, 64'd327680);
    send_cmd(CMD_INIT, 32'h0);
    send_cmd(CMD_PREDICT, 32'h0);
    send_cmd(CMD_UPDATE, 32'h7FFF_FFFF);
    send_cmd(CMD_PREDICT, 32'h0);
    send_cmd(CMD_UPDATE, 32'h8000_0000);
    send_cmd(CMD_PREDICT, 32'h0);
    send_cmd(CMD_UPDATE, 32'h0);
    send_cmd(2'd3, 32'hFFFF_FFFF);
    drain();
    cfg_write(CFG_STEP_DT, 64'd65536);
    cfg_write(CFG_PROC_NOISE, 64'hFFFF_FFFF);
    cfg_write(CFG_START_POS, 64'h7FFF_FFFF);
    cfg_write(CFG_START_VEL, 64'h8000_0000);
    cfg_write(CFG_START_ACC, 64'h7FFF_FFFF);
    cfg_write(CFG_START_TIME, T_MAX);
    send_cmd(CMD_INIT, 32'h0);
    repeat (6) send_cmd(CMD_PREDICT, 32'h0);
    send_cmd(CMD_UPDATE, 32'h8000_0000);
    send_cmd(CMD_UPDATE, 32'h7FFF_FFFF);
    drain();
    cfg_write(CFG_STEP_DT, 64'd1);
    cfg_write(CFG_MEAS_NOISE, 64'hFFFF_FFFF);
    cfg_write(CFG_START_ACC, 64'h8000_0000);
    cfg_write(CFG_START_TIME, 64'd0);
    send_cmd(CMD_INIT, 32'h0);
    send_cmd(CMD_PREDICT, 32'h0);
    send_cmd(CMD_UPDATE, 32'h0001_0000);
    drain();
  endtask

  // Tracking runs of predict and update after an init, mixed with noise.
  task automatic test_random_phase(input int s_pct, input int r_pct, input int n_items);
    int sent;
    int run;
    send_pct = s_pct;
    recv_pct = r_pct;
    random_config();
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(9) < 8) begin
        send_cmd(CMD_INIT, $urandom);
        run = $urandom_range(2, 12);
        for (int i = 0; i < run; i++) begin
          send_cmd(CMD_PREDICT, $urandom);
          send_cmd(CMD_UPDATE, near_meas());
        end
        sent += 1 + 2 * run;
      end else begin
        run = $urandom_range(1, 6);
        for (int i = 0; i < run; i++) send_cmd(2'($urandom_range(0, 3)), $urandom);
        sent += run;
      end
      if ($urandom_range(7) == 0) begin
        drain();
        random_config();
      end
    end
    drain();
  endtask

  // The receiver holds off for a long stretch while items keep coming.
  task automatic test_backpressure;
    send_pct = 0;
    recv_pct = 0;
    random_config();
    hold_req = hold_req + 1;
    send_cmd(CMD_INIT, 32'h0);
    repeat (4) begin
      send_cmd(CMD_PREDICT, 32'h0);
      send_cmd(CMD_UPDATE, near_meas());
    end
    drain();
  endtask

  // Result checker and receiver stall generator.
  always @(posedge clk) begin
    out_item_t e;
    if (!rst) begin
      if (rsp_valid && !rsp_stall) begin
        if (expected_est.size() == 0) begin
          errors = errors + 1;
          if (errors <= 10) $display("unexpected transaction: %h", rsp);
        end else begin
          e = expected_est.pop_front();
          if (rsp.position !== e.position || rsp.velocity !== e.velocity ||
              rsp.acceleration !== e.acceleration ||
              rsp.elapsed_time !== e.elapsed_time || rsp.saturated !== e.saturated) begin
            errors = errors + 1;
            if (errors <= 10)
              $display("mismatch: exp pos %h vel %h acc %h t %h sat %b, got pos %h vel %h acc %h t %h sat %b",
                       e.position, e.velocity, e.acceleration, e.elapsed_time, e.saturated,
                       rsp.position, rsp.velocity, rsp.acceleration, rsp.elapsed_time,
                       rsp.saturated);
          end
        end
      end
      if (hold_cnt > 0) begin
        rsp_stall <= 1'b1;
        hold_cnt <= hold_cnt - 1;
      end else if (hold_req != hold_done) begin
        hold_done <= hold_req;
        hold_cnt <= 3000;
        rsp_stall <= 1'b1;
      end else begin
        rsp_stall <= ($urandom_range(99) < recv_pct);
      end
    end
  end

  initial begin
    rst = 1'b1;
    req_valid = 1'b0;
    req = '0;
    rsp_stall = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    errors = 0;
    send_pct = 0;
    recv_pct = 0;
    hold_req = 0;
    hold_done = 0;
    hold_cnt = 0;
    dt_reg = 64'd2185;
    qn_reg = 64'd3277;
    rn_reg = 64'd327680;
    pos0_reg = 32'd65536;
    vel0_reg = 32'd0;
    acc0_reg = 32'(-642908);
    t0_reg = 64'd0;
    for (int i = 0; i < 3; i++) begin
      est_x[i] = 0;
      pred_x[i] = 0;
    end
    for (int i = 0; i < 9; i++) cov[i] = 0;
    ftime = 64'd0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random_phase(0, 0, 320);
    test_random_phase(57, 0, 320);
    test_random_phase(0, 57, 320);
    test_random_phase(12, 12, 320);
    test_backpressure();
    repeat (600) @(posedge clk);
    if (expected_est.size() != 0) errors = errors + 1;
    if (errors == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
